### src/fps_pkg.sv
// ----------------------------------------------------------------------------
// Frame pixel statistics package
// Shared widths, register indexes and controller/datapath command types.
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int unsigned MAX_FRAME_PIXELS_DEF = 1048576;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_FORMAT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXCLUDE_ENABLE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EXCLUDE_VALUE  = 2'd2;

  localparam logic [1:0] FMT_U8      = 2'd0;
  localparam logic [1:0] FMT_S16     = 2'd1;
  localparam logic [1:0] FMT_U16     = 2'd2;
  // code three reads the same as unsigned 16-bit
  localparam logic [1:0] FMT_U16_ALT = 2'd3;

  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned PIX_W      = 17;
  localparam int unsigned COUNT_W    = 21;
  localparam int unsigned SUM_W      = 38;
  localparam int unsigned SQ_W       = 53;
  localparam int unsigned MAG_W      = 37;
  localparam int unsigned WIDE_W     = 76;
  localparam int unsigned PROD_W     = 96;
  localparam int unsigned DEN_W      = 42;
  localparam int unsigned QUO_W      = 64;
  localparam int unsigned MEAN_W     = 25;
  localparam int unsigned DEV_W      = 24;
  localparam int unsigned FRAME_W    = 16;
  localparam int unsigned MEAN_NUM_W = 45;

  // relative variance threshold, one part in a million
  localparam logic [19:0] VAR_SCALE = 20'd1000000;

  localparam logic signed [PIX_W-1:0] MIN_INIT = 17'sd65535;
  localparam logic signed [PIX_W-1:0] MAX_INIT = -17'sd32768;

  // Controller to datapath
  typedef struct packed {
    logic accumulate;
    logic latch_frame;
    logic mul_step;
    logic div_mean_start;
    logic div_mean_step;
    logic div_var_start;
    logic div_var_step;
    logic sqrt_start;
    logic sqrt_step;
    logic finish;
  } fps_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic sqrt_done;
  } fps_status_t;

endpackage

### src/fps_datapath.sv
// ----------------------------------------------------------------------------
// Frame pixel statistics datapath
// Accumulators, end-of-frame serial multiply, shift-subtract divider and root.
// ----------------------------------------------------------------------------
module fps_datapath #(
  parameter int unsigned MAX_FRAME_PIXELS = fps_pkg::MAX_FRAME_PIXELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  fps_pkg::fps_cmd_t                   cmd,
  output fps_pkg::fps_status_t                status,
  input  logic [1:0]                          sample_format,
  input  logic                                exclude_enable,
  input  logic signed [fps_pkg::PIX_W-1:0]    exclude_value,
  input  logic [15:0]                         pixel_raw,
  output logic [fps_pkg::FRAME_W-1:0]         frame_number,
  output logic [fps_pkg::COUNT_W-1:0]         pixel_count,
  output logic signed [fps_pkg::MEAN_W-1:0]   mean_q8,
  output logic [fps_pkg::DEV_W-1:0]           deviation_q8,
  output logic signed [fps_pkg::PIX_W-1:0]    min_value,
  output logic signed [fps_pkg::PIX_W-1:0]    max_value,
  output logic                                frame_too_long
);
  import fps_pkg::*;

  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_FRAME_PIXELS);

  localparam logic [5:0] LEN_N     = 6'(COUNT_W);
  localparam logic [5:0] LEN_MAG   = 6'(MAG_W);
  localparam logic [5:0] LEN_SCALE = 6'd20;

  typedef enum logic [2:0] {
    MUL_NQ, MUL_SS, MUL_DEN, MUL_SCALE, MUL_DONE
  } mul_sel_t;

  // running accumulators
  logic [COUNT_W-1:0]       count_acc;
  logic signed [SUM_W-1:0]  sum_acc;
  logic [SQ_W-1:0]          square_sum_acc;
  logic signed [PIX_W-1:0]  running_min, running_max;
  logic                     overflow_seen;
  logic [FRAME_W-1:0]       frame_counter;

  logic [COUNT_W-1:0]       count_next;
  logic signed [SUM_W-1:0]  sum_next;
  logic [SQ_W-1:0]          square_sum_next;
  logic signed [PIX_W-1:0]  min_next, max_next;
  logic                     overflow_next;

  logic signed [PIX_W-1:0]  pix;
  logic                     counted;
  logic [33:0]              pix_sq;

  always_comb begin
    if (sample_format == FMT_U8) begin
      pix = PIX_W'($signed({9'd0, pixel_raw[7:0]}));
    end else if (sample_format == FMT_S16) begin
      pix = PIX_W'($signed(pixel_raw));
    end else begin
      pix = $signed({1'b0, pixel_raw});
    end
    counted = !(exclude_enable && pix == exclude_value);
    pix_sq  = $unsigned(34'(pix) * 34'(pix));
  end

  // accumulator update including the pixel of this transaction
  always_comb begin
    count_next      = count_acc;
    sum_next        = sum_acc;
    square_sum_next = square_sum_acc;
    min_next        = running_min;
    max_next        = running_max;
    overflow_next   = overflow_seen;
    if (counted) begin
      if (count_acc >= MAX_CNT) begin
        overflow_next = 1'b1;
      end else begin
        count_next      = count_acc + COUNT_W'(1);
        sum_next        = sum_acc + SUM_W'(pix);
        square_sum_next = square_sum_acc + SQ_W'(pix_sq);
        if (pix < running_min) min_next = pix;
        if (pix > running_max) max_next = pix;
      end
    end
  end

  // frame snapshot
  logic [COUNT_W-1:0]       n_r;
  logic                     neg_r;
  logic [MAG_W-1:0]         mag_r;
  logic [SQ_W-1:0]          q_r;

  // shift-add multiplier, one multiplier bit per cycle: nQ, S*S, n*(n-1), d*1e6
  mul_sel_t                 mul_sel;
  logic                     mul_busy;
  logic [5:0]               mul_cnt;
  logic [PROD_W-1:0]        mul_a, mul_p, mul_sum;
  logic [MAG_W-1:0]         mul_b;
  logic [WIDE_W-1:0]        nq_r, ss_r;
  logic [DEN_W-1:0]         den_r;
  logic [PROD_W-1:0]        dsc_r;

  always_comb mul_sum = mul_p + (mul_b[0] ? mul_a : '0);

  // shift-subtract divider, one quotient bit per cycle
  logic [WIDE_W+16-1:0]     div_num;
  logic [DEN_W-1:0]         div_den;
  logic [DEN_W:0]           div_rem;
  logic [QUO_W-1:0]         div_quo;
  logic                     div_sat;
  logic [6:0]               div_cnt;
  logic [6:0]               div_len;

  logic [DEN_W:0]           rem_shift;
  logic                     rem_ge;
  always_comb begin
    rem_shift = {div_rem[DEN_W-1:0], div_num[WIDE_W+16-1]};
    rem_ge    = rem_shift >= {1'b0, div_den};
  end

  // integer root, two bits per step
  logic [QUO_W-1:0]         sq_x, sq_res, sq_bit;
  logic [QUO_W-1:0]         sq_trial;
  always_comb sq_trial = sq_res + sq_bit;

  // mean quotient is needed after the variance division reuses the divider
  logic [QUO_W-1:0]         mean_hold;

  // variance checks
  logic [WIDE_W-1:0]        d_w;
  logic                     var_zero;
  always_comb begin
    d_w      = nq_r - ss_r;
    var_zero = (n_r <= COUNT_W'(1)) || (nq_r < ss_r)
            || (dsc_r < PROD_W'(nq_r) + PROD_W'(ss_r));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_acc      <= '0;
      sum_acc        <= '0;
      square_sum_acc <= '0;
      running_min    <= MIN_INIT;
      running_max    <= MAX_INIT;
      overflow_seen  <= 1'b0;
      frame_counter  <= '0;
      mul_sel        <= MUL_NQ;
      mul_busy       <= 1'b0;
      div_cnt        <= '0;
      sq_bit         <= '0;
    end else begin
      if (cmd.accumulate) begin
        count_acc      <= count_next;
        sum_acc        <= sum_next;
        square_sum_acc <= square_sum_next;
        running_min    <= min_next;
        running_max    <= max_next;
        overflow_seen  <= overflow_next;
      end
      if (cmd.latch_frame) begin
        n_r            <= count_next;
        neg_r          <= sum_next[SUM_W-1];
        mag_r          <= sum_next[SUM_W-1] ? MAG_W'(-sum_next) : MAG_W'(sum_next);
        q_r            <= square_sum_next;
        frame_number   <= frame_counter;
        pixel_count    <= count_next;
        frame_too_long <= overflow_next;
        min_value      <= (count_next == '0) ? '0 : min_next;
        max_value      <= (count_next == '0) ? '0 : max_next;
        mean_q8        <= '0;
        deviation_q8   <= '0;
        mul_sel        <= MUL_NQ;
        mul_busy       <= 1'b0;
        count_acc      <= '0;
        sum_acc        <= '0;
        square_sum_acc <= '0;
        running_min    <= MIN_INIT;
        running_max    <= MAX_INIT;
        overflow_seen  <= 1'b0;
        frame_counter  <= frame_counter + FRAME_W'(1);
      end
      if (cmd.mul_step) begin
        if (!mul_busy) begin
          mul_p    <= '0;
          mul_busy <= 1'b1;
          unique case (mul_sel)
            MUL_NQ: begin
              mul_a   <= PROD_W'(q_r);
              mul_b   <= MAG_W'(n_r);
              mul_cnt <= LEN_N;
            end
            MUL_SS: begin
              mul_a   <= PROD_W'(mag_r);
              mul_b   <= mag_r;
              mul_cnt <= LEN_MAG;
            end
            MUL_DEN: begin
              mul_a   <= PROD_W'(n_r - COUNT_W'(1));
              mul_b   <= MAG_W'(n_r);
              mul_cnt <= LEN_N;
            end
            MUL_SCALE: begin
              mul_a   <= PROD_W'(d_w);
              mul_b   <= MAG_W'(VAR_SCALE);
              mul_cnt <= LEN_SCALE;
            end
            default: ;
          endcase
        end else begin
          mul_p   <= mul_sum;
          mul_a   <= mul_a << 1;
          mul_b   <= mul_b >> 1;
          mul_cnt <= mul_cnt - 6'd1;
          if (mul_cnt == 6'd1) begin
            mul_busy <= 1'b0;
            unique case (mul_sel)
              MUL_NQ: begin
                nq_r    <= WIDE_W'(mul_sum);
                mul_sel <= MUL_SS;
              end
              MUL_SS: begin
                ss_r    <= WIDE_W'(mul_sum);
                mul_sel <= MUL_DEN;
              end
              MUL_DEN: begin
                den_r   <= DEN_W'(mul_sum);
                mul_sel <= MUL_SCALE;
              end
              MUL_SCALE: begin
                dsc_r   <= mul_sum;
                mul_sel <= MUL_DONE;
              end
              default: ;
            endcase
          end
        end
      end
      if (cmd.div_mean_start) begin
        div_num <= (WIDE_W+16)'({mag_r, 8'd0}) << (WIDE_W+16-MEAN_NUM_W);
        div_den <= DEN_W'(n_r);
        div_rem <= '0;
        div_quo <= '0;
        div_sat <= 1'b0;
        div_cnt <= '0;
        div_len <= 7'(MEAN_NUM_W);
      end
      if (cmd.div_var_start) begin
        div_num <= {d_w, 16'd0};
        div_den <= den_r;
        div_rem <= '0;
        div_quo <= '0;
        div_sat <= 1'b0;
        div_cnt <= '0;
        div_len <= 7'(WIDE_W+16);
      end
      if (cmd.div_mean_step || cmd.div_var_step) begin
        div_num <= div_num << 1;
        div_rem <= rem_ge ? rem_shift - {1'b0, div_den} : rem_shift;
        div_quo <= {div_quo[QUO_W-2:0], rem_ge};
        if (div_quo[QUO_W-1]) div_sat <= 1'b1;
        div_cnt <= div_cnt + 7'd1;
      end
      if (cmd.sqrt_start) begin
        sq_x   <= div_sat ? '1 : div_quo;
        sq_res <= '0;
        sq_bit <= {2'b01, {(QUO_W-2){1'b0}}};
      end
      if (cmd.sqrt_step) begin
        if (sq_x >= sq_trial) begin
          sq_x   <= sq_x - sq_trial;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      if (cmd.finish) begin
        if (n_r != '0) begin
          mean_q8 <= neg_r ? -MEAN_W'(mean_hold) : MEAN_W'(mean_hold);
          if (!var_zero) begin
            deviation_q8 <= (sq_res > QUO_W'(24'hFFFFFF)) ? '1 : DEV_W'(sq_res);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_var_start) mean_hold <= div_quo;
  end

  always_comb begin
    status.mul_done  = (mul_sel == MUL_DONE);
    status.div_done  = (div_cnt == div_len);
    status.sqrt_done = (sq_bit == '0);
  end
endmodule

### src/fps_controller.sv
// ----------------------------------------------------------------------------
// Frame pixel statistics controller
// Sequences accumulate, end-of-frame multiply, divisions and root.
// ----------------------------------------------------------------------------
module fps_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  last_in_frame,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fps_pkg::fps_cmd_t     cmd,
  input  fps_pkg::fps_status_t  status
);
  import fps_pkg::*;

  typedef enum logic [3:0] {
    ST_RUN, ST_MUL, ST_DIVM_GO, ST_DIVM, ST_DIVV_GO, ST_DIVV,
    ST_SQRT_GO, ST_SQRT, ST_DONE, ST_OUT
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == ST_RUN) || (state == ST_OUT && out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.accumulate  = accept;
    cmd.latch_frame = accept && last_in_frame;
    unique case (state)
      ST_MUL:     cmd.mul_step       = !status.mul_done;
      ST_DIVM_GO: cmd.div_mean_start = 1'b1;
      ST_DIVM:    cmd.div_mean_step  = !status.div_done;
      ST_DIVV_GO: cmd.div_var_start  = 1'b1;
      ST_DIVV:    cmd.div_var_step   = !status.div_done;
      ST_SQRT_GO: cmd.sqrt_start     = 1'b1;
      ST_SQRT:    cmd.sqrt_step      = !status.sqrt_done;
      ST_DONE:    cmd.finish         = 1'b1;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_RUN:     if (accept && last_in_frame) state <= ST_MUL;
        ST_MUL:     if (status.mul_done) state <= ST_DIVM_GO;
        ST_DIVM_GO: state <= ST_DIVM;
        ST_DIVM:    if (status.div_done) state <= ST_DIVV_GO;
        ST_DIVV_GO: state <= ST_DIVV;
        ST_DIVV:    if (status.div_done) state <= ST_SQRT_GO;
        ST_SQRT_GO: state <= ST_SQRT;
        ST_SQRT:    if (status.sqrt_done) state <= ST_DONE;
        ST_DONE: begin
          state     <= ST_OUT;
          out_valid <= 1'b1;
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= (accept && last_in_frame) ? ST_MUL : ST_RUN;
          end
        end
        default:    state <= ST_RUN;
      endcase
    end
  end
endmodule

### src/frame_pixel_statistics.sv
// ----------------------------------------------------------------------------
// Frame pixel statistics
// Per-frame count, mean, sample deviation, min and max over a pixel stream.
// ----------------------------------------------------------------------------
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  input   | in_valid/in_ready, pixel_raw, last_in_frame | in
//  output  | out_valid/out_ready, result fields          | out
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data    | in
//
// One pixel per cycle within a frame. After the last pixel the block runs
// four serial products on one shift-add multiplier, a 45-step and a 92-step
// division on one shared divider, and a 32-step root, then offers the
// result. Input stalls meanwhile; the next frame's first pixel is taken in
// the cycle its result transaction completes. Reset clears the accumulators,
// frame counter, configuration and control state, but not the result fields.
module frame_pixel_statistics #(
  parameter int unsigned MAX_FRAME_PIXELS = fps_pkg::MAX_FRAME_PIXELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [15:0]                         pixel_raw,
  input  logic                                last_in_frame,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fps_pkg::FRAME_W-1:0]         frame_number,
  output logic [fps_pkg::COUNT_W-1:0]         pixel_count,
  output logic signed [fps_pkg::MEAN_W-1:0]   mean_q8,
  output logic [fps_pkg::DEV_W-1:0]           deviation_q8,
  output logic signed [fps_pkg::PIX_W-1:0]    min_value,
  output logic signed [fps_pkg::PIX_W-1:0]    max_value,
  output logic                                frame_too_long,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fps_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fps_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fps_pkg::*;

  logic [1:0]              sample_format;
  logic                    exclude_enable;
  logic signed [PIX_W-1:0] exclude_value;
  fps_cmd_t                cmd;
  fps_status_t             status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format  <= '0;
      exclude_enable <= 1'b0;
      exclude_value  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SAMPLE_FORMAT:  sample_format  <= cfg_data[1:0];
        REG_EXCLUDE_ENABLE: exclude_enable <= cfg_data[0];
        REG_EXCLUDE_VALUE:  exclude_value  <= $signed(cfg_data);
        default:            ;
      endcase
    end
  end

  fps_controller u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .last_in_frame,
    .out_valid, .out_ready, .cmd, .status
  );

  fps_datapath #(.MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)) u_dp (
    .clk, .rst, .cmd, .status, .sample_format, .exclude_enable, .exclude_value,
    .pixel_raw, .frame_number, .pixel_count, .mean_q8, .deviation_q8,
    .min_value, .max_value, .frame_too_long
  );

`ifndef NO_ASSERTIONS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready) else $error("input taken while result held");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_dev_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pixel_count <= 21'd1) |-> deviation_q8 == '0) else $error("deviation set");
`endif
endmodule
